>>> sv/substring_occurrence_matcher_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the substring occurrence matcher
// Shared concurrent property forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SUBSTRING_OCCURRENCE_MATCHER_ASSERT_SVH
`define SUBSTRING_OCCURRENCE_MATCHER_ASSERT_SVH

// Same-cycle implication.
`define SOM_ASSERT_IMP(label, clk_i, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SOM_ASSERT_NXT(label, clk_i, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/som_pkg.sv
// ---------------------------------------------------------------------------
// som_pkg
// Types, constants and helper functions of the substring occurrence matcher.
// ---------------------------------------------------------------------------
package som_pkg;

	localparam int NEEDLE_MAX_DEF      = 16;
	localparam int MAX_LINE_LENGTH_DEF = 4096;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam int LINE_W  = 20;
	localparam int START_W = 12;
	localparam int END_W   = 13;
	localparam int LEN_W   = 5;
	localparam int CFG_IW  = 3;

	// Register map of the configuration port.
	typedef enum logic [CFG_IW-1:0] {
		CFG_NEEDLE_LOW  = 3'd0,
		CFG_NEEDLE_HIGH = 3'd1,
		CFG_NEEDLE_LEN  = 3'd2,
		CFG_CASE_SENS   = 3'd3,
		CFG_SEED_LINE   = 3'd4,
		CFG_SEED_START  = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]        text_byte;
		logic [LINE_W-1:0] line_number;
		logic              last_of_line;
	} in_t;

	typedef struct packed {
		logic [LINE_W-1:0]  match_line;
		logic [START_W-1:0] col_first;
		logic [END_W-1:0]   col_past;
		logic               is_primary;
	} out_t;

	typedef struct packed {
		logic [63:0]        needle_low;
		logic [63:0]        needle_high;
		logic [LEN_W-1:0]   needle_length;
		logic               exact_cmp;
		logic [LINE_W-1:0]  anchor_line;
		logic [START_W-1:0] anchor_col;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// ASCII lower-case fold; only 'A'..'Z' change.
	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold);
		if (fold && b >= 8'h41 && b <= 8'h5A) begin
			return b + 8'h20;
		end
		return b;
	endfunction

	function automatic logic [7:0] needle_byte(input cfg_t cfg, input logic [3:0] j);
		logic [127:0] w;
		w = {cfg.needle_high, cfg.needle_low};
		return w[j*8 +: 8];
	endfunction

endpackage

>>> sv/substring_occurrence_matcher.sv
// ---------------------------------------------------------------------------
// substring_occurrence_matcher
// Streaming needle search over line text, one byte word per cycle while item_stall is low.
// ---------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall / item): one text byte per word,
//   tagged with its line index and a last-of-line mark.
//   result channel (result_valid / result_stall / result): one word per
//   occurrence found (line, start column, end column, primary flag).
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while no word is in flight.
// Path: an occurrence completed by an accepted byte passes the compare stage
//   register, then the queue, then the output register driving result.
// Throughput: one byte per cycle while item_stall is low; the compare over
//   the full window is combinational in the front stage.
// Receiver stall: occurrences collect in a QUEUE_DEPTH-entry queue; once it
//   is full and the compare stage holds another, item_stall rises.
// Reset: needle length 1, case-sensitive, needle and seed zero, column 0,
//   queue and output empty. The byte window is not cleared.
// ---------------------------------------------------------------------------
module substring_occurrence_matcher import som_pkg::*; #(
	parameter int NEEDLE_MAX      = NEEDLE_MAX_DEF,
	parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF,
	parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  in_t               item,
	output logic              result_valid,
	input  logic              result_stall,
	output out_t              result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [63:0]       cfg_data
);

	cfg_t      cfg_q;
	logic      push;
	out_t      push_word;
	logic      pop;
	out_t      head;
	q_status_t q_status;

	// Register writes are taken every cycle.
	assign cfg_ready = 1'b1;

	// Hold configuration; decode the index, drop writes beyond the map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.needle_low    <= '0;
			cfg_q.needle_high   <= '0;
			cfg_q.needle_length <= LEN_W'(1);
			cfg_q.exact_cmp     <= 1'b1;
			cfg_q.anchor_line   <= '0;
			cfg_q.anchor_col    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NEEDLE_LOW:  cfg_q.needle_low    <= cfg_data;
				CFG_NEEDLE_HIGH: cfg_q.needle_high   <= cfg_data;
				CFG_NEEDLE_LEN:  cfg_q.needle_length <= cfg_data[LEN_W-1:0];
				CFG_CASE_SENS:   cfg_q.exact_cmp     <= cfg_data[0];
				CFG_SEED_LINE:   cfg_q.anchor_line   <= cfg_data[LINE_W-1:0];
				CFG_SEED_START:  cfg_q.anchor_col    <= cfg_data[START_W-1:0];
				default:         cfg_q               <= cfg_q;
			endcase
		end
	end

	// Front: window, column count and compare.
	som_front #(
		.NEEDLE_MAX      (NEEDLE_MAX),
		.MAX_LINE_LENGTH (MAX_LINE_LENGTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.push_word  (push_word)
	);

	// Queue: decouple the compare from the receiver.
	som_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// Back: registered result word.
	som_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> sv/som_front.sv
// ---------------------------------------------------------------------------
// som_front
// Takes text words, shifts the byte window, counts columns and compares the
// window against the needle; pushes each occurrence into the result queue.
// ---------------------------------------------------------------------------
`include "substring_occurrence_matcher_assert.svh"

module som_front import som_pkg::*; #(
	parameter int NEEDLE_MAX      = NEEDLE_MAX_DEF,
	parameter int MAX_LINE_LENGTH = MAX_LINE_LENGTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_t       item,
	input  q_status_t q_status,
	output logic      push,
	output out_t      push_word
);

	localparam int CW     = $clog2(MAX_LINE_LENGTH + 1);
	localparam int CW1    = CW + 1;
	localparam int XW     = (CW > END_W) ? CW : END_W;
	localparam int WIN_IW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [7:0]        win_q [NEEDLE_MAX];
	logic [CW-1:0]     col_q;
	logic              s1_valid_q;
	logic [CW-1:0]     col_s1_q;
	logic [LINE_W-1:0] line_s1_q;

	logic          accept;
	logic          advance;
	logic          fold;
	logic          cmp_ok;
	logic          len_ok;
	logic          col_ok;
	logic          hit;
	logic [CW-1:0] end_col;
	logic [CW-1:0] start_col;
	logic [XW-1:0] start_x;
	logic [XW-1:0] end_x;

	assign fold = !cfg.exact_cmp;

	// Byte compare over the whole window; positions beyond the needle length drop out.
	always_comb begin
		logic [LEN_W-1:0] pos;
		cmp_ok = 1'b1;
		pos    = '0;
		for (int i = 0; i < NEEDLE_MAX; i++) begin
			pos = cfg.needle_length - LEN_W'(1) - LEN_W'(i);
			if (LEN_W'(i) < cfg.needle_length) begin
				if (fold_byte(win_q[pos[WIN_IW-1:0]], fold) !=
				    fold_byte(needle_byte(cfg, 4'(i)), fold)) begin
					cmp_ok = 1'b0;
				end
			end
		end
	end

	assign len_ok = (cfg.needle_length >= LEN_W'(1)) &&
	                (cfg.needle_length <= LEN_W'(NEEDLE_MAX));
	assign col_ok = (col_s1_q < CW'(MAX_LINE_LENGTH)) &&
	                ((CW1'(col_s1_q) + CW1'(1)) >= CW1'(cfg.needle_length));
	assign hit    = s1_valid_q && len_ok && col_ok && cmp_ok;

	assign end_col   = col_s1_q + CW'(1);
	assign start_col = end_col - CW'(cfg.needle_length);
	assign start_x   = XW'(start_col);
	assign end_x     = XW'(end_col);

	// Hold the stage while its occurrence cannot enter the queue.
	assign item_stall = hit && q_status.full;
	assign advance    = !item_stall;
	assign accept     = item_valid && !item_stall;
	assign push       = hit && !q_status.full;

	always_comb begin
		push_word.match_line = line_s1_q;
		push_word.col_first  = start_x[START_W-1:0];
		push_word.col_past   = end_x[END_W-1:0];
		push_word.is_primary = (line_s1_q == cfg.anchor_line) &&
		                       (start_x == XW'(cfg.anchor_col));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			col_q      <= '0;
		end else if (advance) begin
			s1_valid_q <= accept;
			if (accept) begin
				if (item.last_of_line) begin
					col_q <= '0;
				end else if (col_q < CW'(MAX_LINE_LENGTH)) begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1_q  <= col_q;
			line_s1_q <= item.line_number;
			win_q[0]  <= item.text_byte;
			for (int i = 1; i < NEEDLE_MAX; i++) begin
				win_q[i] <= win_q[i-1];
			end
		end
	end

	`SOM_ASSERT_NXT(a_hit_held, clk, arst_n, hit && q_status.full, s1_valid_q && $stable(col_s1_q), "blocked occurrence lost")
	`SOM_ASSERT_NXT(a_accept_s1, clk, arst_n, accept, s1_valid_q, "accepted word missing from stage")

endmodule

>>> sv/som_queue.sv
// ---------------------------------------------------------------------------
// som_queue
// Short result queue between the compare front and the output stage.
// ---------------------------------------------------------------------------
`include "substring_occurrence_matcher_assert.svh"

module som_queue import som_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_t      push_word,
	input  logic      pop,
	output out_t      head,
	output q_status_t status
);

	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	out_t             mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	`SOM_ASSERT_IMP(a_no_overflow, clk, arst_n, push, !status.full, "push into full queue")
	`SOM_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !status.empty, "pop from empty queue")

endmodule

>>> sv/som_back.sv
// ---------------------------------------------------------------------------
// som_back
// Output register: drains the result queue toward the downstream receiver.
// ---------------------------------------------------------------------------
`include "substring_occurrence_matcher_assert.svh"

module som_back import som_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  out_t      head,
	input  q_status_t q_status,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_t      result
);

	logic valid_q;
	out_t word_q;

	// Load a new word whenever the register is empty or being taken.
	assign pop          = !q_status.empty && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !result_stall) begin
			valid_q <= !q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head;
		end
	end

	`SOM_ASSERT_NXT(a_pop_shows, clk, arst_n, pop, result_valid, "popped word not presented")

endmodule

>>> dv/substring_occurrence_matcher_checker.sv
// ---------------------------------------------------------------------------
// substring_occurrence_matcher_checker
// Watches the item, result and cfg channels of the matcher, keeps its own
// model of the byte window, column and registers, and compares every result
// word with the oldest predicted occurrence.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_occurrence_matcher_checker import som_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  in_t               item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  out_t              result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [63:0]       cfg_data,
	output int                mismatch_count,
	output int                occurrences_due
);

	logic [7:0]         window [NEEDLE_MAX_DEF];
	logic [END_W-1:0]   column;
	logic [127:0]       needle;
	logic [LEN_W-1:0]   needle_len;
	logic               exact;
	logic [LINE_W-1:0]  anchor_line;
	logic [START_W-1:0] anchor_col;
	out_t               due_q [$];
	int                 errors = 0;

	function automatic logic [7:0] to_lower(input logic [7:0] b, input logic caseless);
		if (caseless && b >= 8'h41 && b <= 8'h5A) begin
			return b | 8'h20;
		end
		return b;
	endfunction

	// Shift the byte in, seek the needle ending at it, step or clear the column.
	task automatic predict_occurrence(input in_t w);
		int   len;
		int   col;
		int   stop;
		int   first;
		bit   hit;
		out_t occ;
		for (int i = NEEDLE_MAX_DEF - 1; i > 0; i--) begin
			window[i] = window[i-1];
		end
		window[0] = w.text_byte;
		len = int'(needle_len);
		col = int'(column);
		if (len >= 1 && len <= NEEDLE_MAX_DEF && col < MAX_LINE_LENGTH_DEF && col + 1 >= len) begin
			hit = 1'b1;
			for (int i = 0; i < len; i++) begin
				if (to_lower(window[len-1-i], !exact) != to_lower(needle[i*8 +: 8], !exact)) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				stop = col + 1;
				first = stop - len;
				occ.match_line = w.line_number;
				occ.col_first  = first[START_W-1:0];
				occ.col_past   = stop[END_W-1:0];
				occ.is_primary = (w.line_number == anchor_line) && (first == anchor_col) &&
					(stop == anchor_col + len);
				due_q.insert(due_q.size(), occ);
			end
		end
		if (w.last_of_line) begin
			column = '0;
		end else if (col < MAX_LINE_LENGTH_DEF) begin
			column = END_W'(col + 1);
		end
	endtask

	task automatic check_occurrence(input out_t got);
		out_t want;
		if (due_q.size() == 0) begin
			$error("unexpected occurrence: line %0d start %0d end %0d primary %0d",
				got.match_line, got.col_first, got.col_past, got.is_primary);
			errors++;
		end else begin
			want = due_q.pop_front();
			if (got.match_line !== want.match_line) begin
				$error("match_line: expected %0d, got %0d", want.match_line, got.match_line);
				errors++;
			end
			if (got.col_first !== want.col_first) begin
				$error("col_first: expected %0d, got %0d", want.col_first, got.col_first);
				errors++;
			end
			if (got.col_past !== want.col_past) begin
				$error("col_past: expected %0d, got %0d", want.col_past, got.col_past);
				errors++;
			end
			if (got.is_primary !== want.is_primary) begin
				$error("is_primary: expected %0d, got %0d", want.is_primary, got.is_primary);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NEEDLE_MAX_DEF; i++) begin
				window[i] = '0;
			end
			column      = '0;
			needle      = '0;
			needle_len  = 5'd1;
			exact       = 1'b1;
			anchor_line = '0;
			anchor_col  = '0;
			due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index_t'(cfg_index))
					CFG_NEEDLE_LOW:  needle[63:0]   = cfg_data;
					CFG_NEEDLE_HIGH: needle[127:64] = cfg_data;
					CFG_NEEDLE_LEN:  needle_len     = cfg_data[LEN_W-1:0];
					CFG_CASE_SENS:   exact          = cfg_data[0];
					CFG_SEED_LINE:   anchor_line    = cfg_data[LINE_W-1:0];
					CFG_SEED_START:  anchor_col     = cfg_data[START_W-1:0];
					default: ;
				endcase
			end
			// A result word never belongs to the byte taken at the same edge.
			if (result_valid && !result_stall) begin
				check_occurrence(result);
			end
			if (item_valid && !item_stall) begin
				predict_occurrence(item);
			end
		end
		mismatch_count  <= errors;
		occurrences_due <= due_q.size();
	end

endmodule

>>> dv/substring_occurrence_matcher_test.sv
// ---------------------------------------------------------------------------
// substring_occurrence_matcher_test
// Drives text lines through the matcher under changing needle, case and seed
// settings: a short directed opening, then random phases with planted
// needles and one receiver hold-off that backs up the input. A separate
// checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_occurrence_matcher_test;
	import som_pkg::*;

	localparam int RANDOM_ITEMS   = 1850;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SQUEEZE_CYCLES = 400;
	// Margin for bytes still in the pipeline that complete nothing.
	localparam int DRAIN_CYCLES   = 8;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_stall;
	in_t               item;
	logic              result_valid;
	logic              result_stall;
	out_t              result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [63:0]       cfg_data;
	int                mismatch_count;
	int                occurrences_due;

	// Copy of the needle as last programmed, used to plant occurrences in text.
	logic [7:0] needle_sel [NEEDLE_MAX_DEF];
	int         needle_len_sel;
	logic [7:0] text_buf [$];
	bit         squeeze_req;
	bit         tight_phase;
	int         random_items;
	int         quiet_cycles = 0;

	substring_occurrence_matcher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	substring_occurrence_matcher_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.occurrences_due (occurrences_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort when no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Mostly back-to-back words, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Text draws mostly on a few letters and the bytes that border the
	// case-fold range, so short needles hit often; the rest is any byte.
	function automatic logic [7:0] pick_text_byte();
		int         r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			case ($urandom_range(0, 9))
				0:       b = 8'h61;
				1:       b = 8'h41;
				2:       b = 8'h62;
				3:       b = 8'h42;
				4:       b = 8'h7A;
				5:       b = 8'h5A;
				6:       b = 8'h40;
				7:       b = 8'h5B;
				8:       b = 8'h60;
				default: b = 8'h7B;
			endcase
		end else if (r < 85) begin
			b = 8'($urandom_range(0, 127));
		end else begin
			b = 8'($urandom_range(128, 255));
		end
		return b;
	endfunction

	// Flip the case of a letter now and then: a near miss when exact.
	function automatic logic [7:0] vary_case(input logic [7:0] b);
		logic [7:0] low;
		low = b | 8'h20;
		if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 3) == 0) begin
			return b ^ 8'h20;
		end
		return b;
	endfunction

	function automatic bit needle_usable();
		return needle_len_sel >= 1 && needle_len_sel <= NEEDLE_MAX_DEF;
	endfunction

	task automatic plant_needle(input int at);
		for (int j = 0; j < needle_len_sel; j++) begin
			text_buf[at + j] = vary_case(needle_sel[j]);
		end
	endtask

	// Offer one byte word, after an optional gap; hold it until taken.
	task automatic push_byte(input logic [7:0] b, input logic [LINE_W-1:0] ln, input logic last);
		in_t w;
		int  gap;
		w.text_byte    = b;
		w.line_number  = ln;
		w.last_of_line = last;
		gap = tight_phase ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	// Leave cfg_valid high; the caller drops it after the last write.
	task automatic write_reg(input cfg_index_t idx, input logic [63:0] d);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] len_w, input logic [63:0] case_w,
		input logic [63:0] line_w, input logic [63:0] start_w);
		write_reg(CFG_NEEDLE_LOW, lo);
		write_reg(CFG_NEEDLE_HIGH, hi);
		write_reg(CFG_NEEDLE_LEN, len_w);
		write_reg(CFG_CASE_SENS, case_w);
		write_reg(CFG_SEED_LINE, line_w);
		write_reg(CFG_SEED_START, start_w);
		cfg_valid <= 1'b0;
		for (int j = 0; j < 8; j++) begin
			needle_sel[j]     = lo[j*8 +: 8];
			needle_sel[j + 8] = hi[j*8 +: 8];
		end
		needle_len_sel = int'(len_w[LEN_W-1:0]);
	endtask

	// Drop valid, wait for every predicted occurrence, then let the
	// pipeline empty of bytes that complete nothing.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (occurrences_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: short and long stalls, free-running stretches, and one long
	// hold-off on request so the queue fills and the input backs up.
	initial begin
		int run;
		int hold;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				result_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				run  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
				hold = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
				result_stall <= 1'b0;
				repeat (run) @(posedge clk);
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin
		int                phase_no;
		int                budget;
		int                sent;
		int                k;
		int                r;
		int                len_pick;
		int                line_len;
		int                seed_k;
		int                seed_col;
		int                plants;
		bit                mark;
		logic [LINE_W-1:0] base;
		logic [LINE_W-1:0] ln;
		logic [LINE_W-1:0] seed_ln;
		logic [63:0]       lo;
		logic [63:0]       hi;
		logic [63:0]       w_len;
		logic [63:0]       w_case;
		logic [63:0]       w_line;
		logic [63:0]       w_start;

		phase_no       = 0;
		random_items   = 0;
		squeeze_req    = 1'b0;
		tight_phase    = 1'b0;
		needle_len_sel = 1;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one-byte needle 0x00, exact, seed at line 0 column 0.
		// The second byte switches line without a mark, so its column runs on.
		push_byte(8'h00, 20'h00000, 1'b0);
		push_byte(8'h00, 20'hFFFFF, 1'b1);

		// Case-folded two-byte needle, two hits on the seed line, the first
		// primary; a non-ASCII byte next to a letter must not fold.
		settle();
		apply_config(64'h5A61, 64'h0, 64'd2, 64'd0, 64'd5, 64'd1);
		push_byte(8'h58, 20'd5, 1'b0);
		push_byte(8'h41, 20'd5, 1'b0);
		push_byte(8'h7A, 20'd5, 1'b0);
		push_byte(8'h61, 20'd5, 1'b0);
		push_byte(8'h5A, 20'd5, 1'b1);
		push_byte(8'hE1, 20'd6, 1'b0);
		push_byte(8'h7A, 20'd6, 1'b1);

		// Invalid needle lengths: zero and beyond the window report nothing.
		settle();
		apply_config(64'h0, 64'h0, 64'd0, 64'd1, 64'd0, 64'd0);
		push_byte(8'h00, 20'd0, 1'b1);
		settle();
		apply_config(64'h0, 64'h0, 64'd31, 64'd1, 64'd0, 64'd0);
		push_byte(8'h00, 20'd0, 1'b1);

		// Full-window needle of arbitrary bytes on the top line index.
		settle();
		lo = {$urandom, $urandom};
		hi = {$urandom, $urandom};
		apply_config(lo, hi, 64'd16, 64'd1, 64'hFFFFF, 64'd0);
		for (int j = 0; j < NEEDLE_MAX_DEF; j++) begin
			push_byte(needle_sel[j], 20'hFFFFF, j == NEEDLE_MAX_DEF - 1);
		end

		while (random_items < RANDOM_ITEMS) begin
			if (phase_no == 2) begin
				// Every byte matches; hold the receiver off while words keep coming.
				settle();
				hi = {$urandom, $urandom};
				apply_config(64'h61, hi, 64'd1, 64'd0, {$urandom, $urandom}, 64'd0);
				tight_phase = 1'b1;
				squeeze_req = 1'b1;
				while (squeeze_req) @(posedge clk);
				base = LINE_W'($urandom);
				for (int j = 0; j < 120; j++) begin
					ln = base + LINE_W'(j / 30);
					push_byte(($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41, ln, (j % 30) == 29);
				end
				random_items += 120;
			end else begin
				// Random settings; short needles most of the time.
				r = $urandom_range(0, 99);
				if (r < 8) begin
					len_pick = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(17, 31);
				end else if (r < 60) begin
					len_pick = $urandom_range(1, 3);
				end else if (r < 85) begin
					len_pick = $urandom_range(4, 8);
				end else begin
					len_pick = $urandom_range(9, 16);
				end
				for (int j = 0; j < 8; j++) begin
					lo[j*8 +: 8] = pick_text_byte();
					hi[j*8 +: 8] = pick_text_byte();
				end
				base     = LINE_W'($urandom);
				seed_k   = $urandom_range(0, 3);
				seed_col = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0) begin
					seed_ln = LINE_W'($urandom);
				end else begin
					seed_ln = base + LINE_W'(seed_k);
				end
				// Junk in the upper bits of the narrow registers must be ignored.
				w_len  = {$urandom, $urandom};
				w_len[LEN_W-1:0] = LEN_W'(len_pick);
				w_case = {$urandom, $urandom};
				w_line = {$urandom, $urandom};
				w_line[LINE_W-1:0] = seed_ln;
				w_start = {$urandom, $urandom};
				w_start[START_W-1:0] = START_W'(seed_col);
				settle();
				apply_config(lo, hi, w_len, w_case, w_line, w_start);
				tight_phase = ($urandom_range(0, 3) == 0);
				budget = $urandom_range(40, 160);
				sent   = 0;
				k      = 0;
				while (sent < budget) begin
					line_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) :
						$urandom_range(25, 70);
					if (k == seed_k && needle_usable() && line_len < seed_col + needle_len_sel) begin
						line_len = seed_col + needle_len_sel;
					end
					text_buf.delete();
					for (int j = 0; j < line_len; j++) begin
						text_buf = {text_buf, pick_text_byte()};
					end
					// Plant a few needles, and one exactly on the seed selection.
					if (needle_usable()) begin
						plants = $urandom_range(0, 2);
						for (int j = 0; j < plants; j++) begin
							if (line_len >= needle_len_sel) begin
								plant_needle($urandom_range(0, line_len - needle_len_sel));
							end
						end
						if (k == seed_k) begin
							plant_needle(seed_col);
						end
					end
					// Now and then leave the mark off so the column runs into the next line.
					mark = ($urandom_range(0, 9) != 0);
					ln = base + LINE_W'(k);
					for (int j = 0; j < line_len; j++) begin
						push_byte(text_buf[j], ln, mark && (j == line_len - 1));
					end
					sent += line_len;
					k++;
				end
				random_items += sent;
			end
			phase_no++;
		end

		settle();
		if (mismatch_count == 0 && occurrences_due == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/som_pkg.sv
sv/som_front.sv
sv/som_queue.sv
sv/som_back.sv
sv/substring_occurrence_matcher.sv
dv/substring_occurrence_matcher_checker.sv
dv/substring_occurrence_matcher_test.sv
